>>> design/knnbc_pkg.sv
package knnbc_pkg;

  // Command codes carried by an input beat
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

  // Result vote fields
  localparam int VOTE_W = 4;

  // Configuration register map
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int KCFG_W = 4;
  localparam logic [KCFG_W-1:0] KCFG_RESET = 4'd3;
  localparam logic REG_NEIGHBOUR_COUNT = 1'b0;

  // Status of the distance pipeline as seen by the sequencer and the list
  typedef struct packed {
    logic busy;
    logic valid;
    logic label;
  } dist_stat_t;

endpackage

>>> design/knnbc_in_if.sv
interface knnbc_in_if
  import knnbc_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic [CMD_W-1:0]              command;
  logic signed [COORD_WIDTH-1:0] coord_x;
  logic signed [COORD_WIDTH-1:0] coord_y;
  logic                          label;

  modport source (output valid, output command, output coord_x, output coord_y,
                  output label, input ready);
  modport sink   (input valid, input command, input coord_x, input coord_y,
                  input label, output ready);
endinterface

>>> design/knnbc_out_if.sv
interface knnbc_out_if
  import knnbc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              predicted_class;
  logic [VOTE_W-1:0] votes_zero;
  logic [VOTE_W-1:0] votes_one;
  logic              k_clamped;

  modport source (output valid, output predicted_class, output votes_zero,
                  output votes_one, output k_clamped, input ready);
  modport sink   (input valid, input predicted_class, input votes_zero,
                  input votes_one, input k_clamped, output ready);
endinterface

>>> design/knnbc_point_mem.sv
module knnbc_point_mem
  import knnbc_pkg::*;
#(
  parameter int DATA_W = 33,
  parameter int DEPTH  = 64,
  parameter int AW     = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data,
  output logic              rd_valid
);

  logic [DATA_W-1:0] store_mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_valid_r;

  // Write one point per load beat
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  // Track which cycles carry read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_en;
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = rd_valid_r;

endmodule

>>> design/knnbc_dist.sv
module knnbc_dist
  import knnbc_pkg::*;
#(
  parameter int CW     = 16,
  parameter int DIST_W = 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pt_valid,
  input  logic [CW-1:0] pt_x,
  input  logic [CW-1:0] pt_y,
  input  logic          pt_label,
  input  logic [CW-1:0] q_x,
  input  logic [CW-1:0] q_y,
  output logic [DIST_W-1:0] sq_dist,
  output dist_stat_t    stat
);

  localparam int SQ_W  = 2 * CW;
  localparam int SUM_W = SQ_W + 1;

  logic [CW:0]       dx, dy, ndx, ndy;
  logic [CW-1:0]     ax, ay;
  logic [SQ_W-1:0]   sqx, sqy;
  logic [SUM_W-1:0]  sum;
  logic [DIST_W-1:0] dsat;

  logic              v1_r, v2_r, v3_r;
  logic              l1_r, l2_r, l3_r;
  logic [CW-1:0]     ax_r, ay_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r;
  logic [DIST_W-1:0] d_r;

  // Absolute coordinate differences, which always fit CW bits
  always_comb begin
    dx  = {pt_x[CW-1], pt_x} - {q_x[CW-1], q_x};
    dy  = {pt_y[CW-1], pt_y} - {q_y[CW-1], q_y};
    ndx = '0 - dx;
    ndy = '0 - dy;
    ax  = dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
    ay  = dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
  end

  assign sqx = ax_r * ax_r;
  assign sqy = ay_r * ay_r;
  assign sum = SUM_W'(sqx_r) + SUM_W'(sqy_r);

  // Saturate the sum only when it can outgrow the distance word
  generate
    if (SUM_W > DIST_W) begin : g_sat
      assign dsat = (|sum[SUM_W-1:DIST_W]) ? '1 : sum[DIST_W-1:0];
    end else begin : g_nosat
      assign dsat = DIST_W'(sum);
    end
  endgenerate

  // Stage payloads
  always_ff @(posedge clk) begin
    ax_r  <= ax;
    ay_r  <= ay;
    l1_r  <= pt_label;
    sqx_r <= sqx;
    sqy_r <= sqy;
    l2_r  <= l1_r;
    d_r   <= dsat;
    l3_r  <= l2_r;
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= pt_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign sq_dist    = d_r;
  assign stat.busy  = v1_r | v2_r | v3_r;
  assign stat.valid = v3_r;
  assign stat.label = l3_r;

endmodule

>>> design/knnbc_best_list.sv
module knnbc_best_list
  import knnbc_pkg::*;
#(
  parameter int MAX_K  = 15,
  parameter int DIST_W = 33,
  parameter int KW     = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic [KW-1:0]     k_eff,
  input  logic [DIST_W-1:0] ins_dist,
  input  dist_stat_t        ins_stat,
  output logic [KW-1:0]     votes_zero,
  output logic [KW-1:0]     votes_one
);

  localparam int KIW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  logic [DIST_W-1:0] dist_r   [MAX_K];
  logic [DIST_W-1:0] dist_nxt [MAX_K];
  logic [DIST_W-1:0] sh_dist  [MAX_K];
  logic [MAX_K-1:0]  lab_r, lab_nxt, sh_lab;
  logic [MAX_K-1:0]  vld_r, vld_nxt, sh_vld;
  logic [MAX_K-1:0]  le;
  logic [MAX_K:0]    le_ext;
  logic [KW-1:0]     z_r, o_r, z_nxt, o_nxt;
  logic [KW-1:0]     k_last;
  logic [KIW-1:0]    kidx;
  logic              ins_ok, evict, ev_lab, do_ins;

  // Compare against every kept entry, then shift the tail down by one
  always_comb begin
    for (int j = 0; j < MAX_K; j++) begin
      le[j] = vld_r[j] && (dist_r[j] <= ins_dist);
    end
    le_ext = {le, 1'b1};
    sh_dist[0] = ins_dist;
    sh_lab[0]  = ins_stat.label;
    sh_vld[0]  = 1'b1;
    for (int j = 1; j < MAX_K; j++) begin
      sh_dist[j] = dist_r[j-1];
      sh_lab[j]  = lab_r[j-1];
      sh_vld[j]  = vld_r[j-1];
    end

    k_last = k_eff - KW'(1);
    kidx   = k_last[KIW-1:0];
    ins_ok = (k_eff != '0) && !le[kidx];
    evict  = ins_ok && vld_r[kidx];
    ev_lab = lab_r[kidx];
    do_ins = ins_stat.valid && ins_ok;

    for (int j = 0; j < MAX_K; j++) begin
      dist_nxt[j] = dist_r[j];
      lab_nxt[j]  = lab_r[j];
      vld_nxt[j]  = vld_r[j];
      if (do_ins && (j < int'(k_eff)) && !le[j]) begin
        if (le_ext[j]) begin
          dist_nxt[j] = ins_dist;
          lab_nxt[j]  = ins_stat.label;
          vld_nxt[j]  = 1'b1;
        end else begin
          dist_nxt[j] = sh_dist[j];
          lab_nxt[j]  = sh_lab[j];
          vld_nxt[j]  = sh_vld[j];
        end
      end
    end

    // Keep running vote counts: add the newcomer, drop the evicted entry
    z_nxt = z_r;
    o_nxt = o_r;
    if (do_ins) begin
      z_nxt = z_r + KW'(!ins_stat.label) - KW'(evict && !ev_lab);
      o_nxt = o_r + KW'(ins_stat.label) - KW'(evict && ev_lab);
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    lab_r  <= lab_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      vld_r <= '0;
      z_r   <= '0;
      o_r   <= '0;
    end else begin
      vld_r <= vld_nxt;
      z_r   <= z_nxt;
      o_r   <= o_nxt;
    end
  end

  assign votes_zero = z_r;
  assign votes_one  = o_r;

endmodule

>>> design/knn_binary_classifier_core.sv
// k-nearest-neighbor classifier over signed Q8.8 2-D points. A load beat
// stores one labelled point in the next free entry of a two-port point
// memory (ignored once MAX_POINTS are stored) and a clear beat empties it. A
// classify beat sweeps the memory one point per cycle through a three-stage
// squared-distance pipeline into a sorted list of the k closest points (ties
// keep the earlier load), with vote counts kept as points enter and leave the
// list. The length of a query is set by the one read per cycle of the point
// memory, plus any wait for the result register to drain; with an empty store
// the sweep is skipped. Further beats are taken again once the result is
// registered; a load or clear can be taken while a result still waits. k
// comes from the neighbour_count register, saturates at MAX_K and is clamped
// to the stored count, which raises k_clamped. Class 0 is reported only on a
// strict majority of 0 votes. The store has no reset; the point count does.
module knn_binary_classifier_core
  import knnbc_pkg::*;
#(
  parameter int MAX_POINTS  = 64,
  parameter int MAX_K       = 15,
  parameter int COORD_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  knnbc_in_if.sink              in_beat,
  knnbc_out_if.source           out_beat,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CW     = COORD_WIDTH;
  localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PW     = $clog2(MAX_POINTS + 1);
  localparam int KW     = $clog2(MAX_K + 1);
  localparam int SUM_W  = 2 * CW + 1;
  localparam int DIST_W = (SUM_W > 64) ? 64 : SUM_W;
  localparam int MEM_W  = 2 * CW + 1;

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_DRAIN, S_RESULT} state_t;

  state_t              state_r;
  logic [PW-1:0]       count_r;
  logic [AW-1:0]       addr_r;
  logic [CW-1:0]       qx_r, qy_r;
  logic [KW-1:0]       k_eff_r;
  logic                clamped_r;
  logic [KCFG_W-1:0]   k_cfg_r;
  logic                out_valid_r, pred_r, kc_r;
  logic [VOTE_W-1:0]   vz_r, vo_r;

  logic                in_acc, full, last_addr, out_free, cfg_wr;
  logic [KW-1:0]       k_sat, k_eff;
  logic                clamp;
  logic                wr_en, rd_en, rd_valid;
  logic [MEM_W-1:0]    wr_data, rd_data;
  logic [DIST_W-1:0]   sq_dist;
  dist_stat_t          dstat;
  logic [KW-1:0]       votes_zero, votes_one;

  assign in_acc    = in_beat.valid && in_beat.ready;
  assign full      = int'(count_r) >= MAX_POINTS;
  assign last_addr = PW'(addr_r) == (count_r - PW'(1));
  assign out_free  = !out_valid_r || out_beat.ready;
  assign cfg_wr    = psel && penable && pwrite && pready;

  // Effective k: saturate at MAX_K, then clamp to the stored count
  always_comb begin
    if (int'(k_cfg_r) > MAX_K) begin
      k_sat = KW'(MAX_K);
    end else begin
      k_sat = KW'(k_cfg_r);
    end
    if (int'(k_sat) > int'(count_r)) begin
      k_eff = KW'(count_r);
      clamp = 1'b1;
    end else begin
      k_eff = k_sat;
      clamp = 1'b0;
    end
  end

  assign wr_en   = in_acc && (in_beat.command == CMD_LOAD) && !full;
  assign wr_data = {in_beat.label, in_beat.coord_y, in_beat.coord_x};
  assign rd_en   = (state_r == S_SWEEP);

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise the result beat when it is registered, drop it once taken
      if ((state_r == S_RESULT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_beat.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_beat.command)
              CMD_LOAD: begin
                if (!full) begin
                  count_r <= count_r + PW'(1);
                end
              end
              CMD_CLEAR: begin
                count_r <= '0;
              end
              CMD_CLASSIFY: begin
                qx_r      <= in_beat.coord_x;
                qy_r      <= in_beat.coord_y;
                k_eff_r   <= k_eff;
                clamped_r <= clamp;
                addr_r    <= '0;
                state_r   <= (count_r == '0) ? S_DRAIN : S_SWEEP;
              end
              default: begin
              end
            endcase
          end
        end
        S_SWEEP: begin
          addr_r <= addr_r + AW'(1);
          if (last_addr) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_valid && !dstat.busy) begin
            state_r <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            pred_r      <= !(votes_zero > votes_one);
            vz_r        <= VOTE_W'(votes_zero);
            vo_r        <= VOTE_W'(votes_one);
            kc_r        <= clamped_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_cfg_r <= KCFG_RESET;
    end else if (cfg_wr && (paddr[2] == REG_NEIGHBOUR_COUNT)) begin
      k_cfg_r <= pwdata[KCFG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NEIGHBOUR_COUNT) ? CFG_DATA_W'(k_cfg_r) : '0;

  assign in_beat.ready            = (state_r == S_IDLE);
  assign out_beat.valid           = out_valid_r;
  assign out_beat.predicted_class = pred_r;
  assign out_beat.votes_zero      = vz_r;
  assign out_beat.votes_one       = vo_r;
  assign out_beat.k_clamped       = kc_r;

  knnbc_point_mem #(
    .DATA_W (MEM_W),
    .DEPTH  (MAX_POINTS),
    .AW     (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (count_r[AW-1:0]),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (addr_r),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  knnbc_dist #(
    .CW     (CW),
    .DIST_W (DIST_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .pt_valid (rd_valid),
    .pt_x     (rd_data[CW-1:0]),
    .pt_y     (rd_data[2*CW-1:CW]),
    .pt_label (rd_data[2*CW]),
    .q_x      (qx_r),
    .q_y      (qy_r),
    .sq_dist  (sq_dist),
    .stat     (dstat)
  );

  knnbc_best_list #(
    .MAX_K  (MAX_K),
    .DIST_W (DIST_W),
    .KW     (KW)
  ) u_list (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (in_acc && (in_beat.command == CMD_CLASSIFY)),
    .k_eff      (k_eff_r),
    .ins_dist   (sq_dist),
    .ins_stat   (dstat),
    .votes_zero (votes_zero),
    .votes_one  (votes_one)
  );

endmodule

>>> design/knnbc_checker.sv
module knnbc_checker
  import knnbc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [CMD_W-1:0]  in_command,
  input logic              out_valid,
  input logic              out_ready,
  input logic              predicted_class,
  input logic [VOTE_W-1:0] votes_zero,
  input logic [VOTE_W-1:0] votes_one,
  input logic              k_clamped
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(predicted_class) &&
    $stable(votes_zero) && $stable(votes_one) && $stable(k_clamped))
    else $error("result beat changed while stalled");

  // Class 0 only on a strict majority of zero votes
  a_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (predicted_class == (votes_zero <= votes_one)))
    else $error("predicted class disagrees with votes");

  // Reset leaves no result and an open input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear result or input stall");

  // Taking a query stalls the input
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_CLASSIFY) |=> !in_ready)
    else $error("input taken right after a query");

endmodule

bind knn_binary_classifier_core knnbc_checker u_knnbc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_beat.valid),
  .in_ready        (in_beat.ready),
  .in_command      (in_beat.command),
  .out_valid       (out_beat.valid),
  .out_ready       (out_beat.ready),
  .predicted_class (out_beat.predicted_class),
  .votes_zero      (out_beat.votes_zero),
  .votes_one       (out_beat.votes_one),
  .k_clamped       (out_beat.k_clamped)
);

>>> tb/sv/tb_knn_binary_classifier_core.sv
module tb_knn_binary_classifier_core;
  timeunit 1ns;
  timeprecision 1ps;
  import knnbc_pkg::*;

  localparam int N_POINTS     = 64;
  localparam int N_K          = 15;
  localparam int COORD_W      = 16;
  localparam int TARGET_BEATS = 1550;
  localparam int DRAIN_CYCLES = 80;
  localparam int N_ROWS       = 23;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic              predicted_class;
    logic [VOTE_W-1:0] votes_zero;
    logic [VOTE_W-1:0] votes_one;
    logic              k_clamped;
  } verdict_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    coord_t           x;
    coord_t           y;
    logic             label;
    logic             typed;
    verdict_t         want;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  knnbc_in_if #(.COORD_WIDTH(COORD_W)) in_if ();
  knnbc_out_if out_if ();

  knn_binary_classifier_core #(
    .MAX_POINTS (N_POINTS),
    .MAX_K      (N_K),
    .COORD_WIDTH(COORD_W)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_beat (in_if),
    .out_beat(out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Directed rows; typed expectations only where they are obvious
  plan_row_t directed_plan [N_ROWS] = '{
    '{CMD_CLASSIFY, 16'sh0000, 16'sh0000, 1'b0, 1'b1, '{1'b1, 4'd0, 4'd0, 1'b1}},
    '{CMD_UNUSED,   16'sh7fff, 16'shffff, 1'b1, 1'b0, '0},
    '{CMD_LOAD,     16'sh8000, 16'sh8000, 1'b0, 1'b0, '0},
    '{CMD_LOAD,     16'sh7fff, 16'sh7fff, 1'b1, 1'b0, '0},
    '{CMD_CLASSIFY, 16'sh0000, 16'sh0000, 1'b0, 1'b1, '{1'b1, 4'd1, 4'd1, 1'b1}},
    '{CMD_LOAD,     16'sh0000, 16'sh0000, 1'b0, 1'b0, '0},
    '{CMD_CLASSIFY, 16'sh8000, 16'sh8000, 1'b1, 1'b1, '{1'b0, 4'd2, 4'd1, 1'b0}},
    '{CMD_CLASSIFY, 16'sh7fff, 16'sh8000, 1'b0, 1'b0, '0},
    '{CMD_CLEAR,    16'sh0000, 16'sh0000, 1'b1, 1'b0, '0},
    '{CMD_CLASSIFY, 16'sh0001, 16'shffff, 1'b0, 1'b1, '{1'b1, 4'd0, 4'd0, 1'b1}},
    '{CMD_LOAD,     16'sh0100, 16'sh0000, 1'b1, 1'b0, '0},
    '{CMD_LOAD,     16'shff00, 16'sh0000, 1'b0, 1'b0, '0},
    '{CMD_LOAD,     16'sh0000, 16'sh0100, 1'b0, 1'b0, '0},
    '{CMD_LOAD,     16'sh0000, 16'shff00, 1'b1, 1'b0, '0},
    '{CMD_CLASSIFY, 16'sh0000, 16'sh0000, 1'b0, 1'b0, '0},
    '{CMD_LOAD,     16'sh0000, 16'sh0000, 1'b1, 1'b0, '0},
    '{CMD_CLASSIFY, 16'sh0000, 16'sh0000, 1'b0, 1'b0, '0},
    '{CMD_LOAD,     16'shffff, 16'shffff, 1'b0, 1'b0, '0},
    '{CMD_CLASSIFY, 16'shffff, 16'shffff, 1'b1, 1'b0, '0},
    '{CMD_LOAD,     16'sh5555, 16'shaaaa, 1'b1, 1'b0, '0},
    '{CMD_CLASSIFY, 16'shaaaa, 16'sh5555, 1'b0, 1'b0, '0},
    '{CMD_CLEAR,    16'sh0000, 16'sh0000, 1'b0, 1'b0, '0},
    '{CMD_UNUSED,   16'sh0000, 16'sh0000, 1'b0, 1'b0, '0}
  };

  // Shadow copy of the point store and the k register
  coord_t            stored_x   [N_POINTS];
  coord_t            stored_y   [N_POINTS];
  logic              stored_lab [N_POINTS];
  int                stored_count = 0;
  logic [KCFG_W-1:0] k_setting    = KCFG_RESET;

  verdict_t expected_verdicts [$];

  int send_idle = 9;
  int recv_idle = 85;
  int errors       = 0;
  int results_seen = 0;
  int beats_counted = 0;
  int n_queries = 0;
  int n_loads = 0;
  int n_full_loads = 0;
  int n_clears = 0;
  int n_unused = 0;
  logic [15:0] k_seen = 16'h0008;

  // Rank stored points by squared distance, keep the k closest, count votes
  function automatic verdict_t classify_query(input coord_t qx, input coord_t qy);
    longint unsigned near_dist [N_K];
    int              near_idx  [N_K];
    int              k;
    int              kept;
    int              pos;
    int              zeros;
    int              ones;
    longint          dx;
    longint          dy;
    longint unsigned d;
    verdict_t        v;
    v = '0;
    kept = 0;
    zeros = 0;
    ones = 0;
    k = int'(k_setting);
    if (k > N_K) k = N_K;
    if (k > stored_count) begin
      k = stored_count;
      v.k_clamped = 1'b1;
    end
    for (int i = 0; i < stored_count; i++) begin
      dx = longint'(stored_x[i]) - longint'(qx);
      dy = longint'(stored_y[i]) - longint'(qy);
      d = dx * dx + dy * dy;
      pos = 0;
      // equal distance stays behind the earlier load
      while (pos < kept && near_dist[pos] <= d) pos++;
      if (pos < k) begin
        if (kept < k) kept++;
        for (int j = kept - 1; j > pos; j--) begin
          near_dist[j] = near_dist[j-1];
          near_idx[j]  = near_idx[j-1];
        end
        near_dist[pos] = d;
        near_idx[pos]  = i;
      end
    end
    for (int i = 0; i < kept; i++) begin
      if (stored_lab[near_idx[i]]) ones++;
      else zeros++;
    end
    v.predicted_class = !(zeros > ones);
    v.votes_zero = VOTE_W'(zeros);
    v.votes_one  = VOTE_W'(ones);
    return v;
  endfunction

  // Advance the shadow store by one beat; return 1 when a result is due
  function automatic bit apply_beat(input logic [CMD_W-1:0] cmd, input coord_t x,
                                    input coord_t y, input logic lab,
                                    output verdict_t v);
    v = '0;
    case (cmd)
      CMD_LOAD: begin
        if (stored_count < N_POINTS) begin
          stored_x[stored_count]   = x;
          stored_y[stored_count]   = y;
          stored_lab[stored_count] = lab;
          stored_count++;
        end
      end
      CMD_CLEAR: begin
        stored_count = 0;
      end
      CMD_CLASSIFY: begin
        v = classify_query(x, y);
        return 1'b1;
      end
      default: begin
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Mostly clustered values so ties and split votes are common
  function automatic coord_t pick_coord();
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 50) begin
      v = (int'($urandom_range(8)) - 4) * 128;
    end else if (sel < 80) begin
      v = int'($urandom_range(4095)) - 2048;
    end else if (sel < 86) begin
      v = $urandom_range(1) ? 32767 : -32768;
    end else begin
      v = int'($urandom);
    end
    return coord_t'(v);
  endfunction

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Result side: stall at random
  always @(negedge clk) out_if.ready <= ($urandom_range(99) >= recv_idle);

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t ns: result beat with none expected, actual class %0d votes %0d/%0d clamp %0d",
                 $time, out_if.predicted_class, out_if.votes_zero, out_if.votes_one,
                 out_if.k_clamped);
      end else begin
        want = expected_verdicts.pop_front();
        check_field("predicted_class", want.predicted_class, out_if.predicted_class);
        check_field("votes_zero", want.votes_zero, out_if.votes_zero);
        check_field("votes_one", want.votes_one, out_if.votes_one);
        check_field("k_clamped", want.k_clamped, out_if.k_clamped);
      end
    end
  end

  // Send one beat, hold until taken, then update the shadow store
  task automatic push_beat(input logic [CMD_W-1:0] cmd, input coord_t x, input coord_t y,
                           input logic lab, input logic typed, input verdict_t want);
    verdict_t v;
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.coord_x <= x;
    in_if.coord_y <= y;
    in_if.label   <= lab;
    do @(posedge clk); while (!in_if.ready);
    beats_counted++;
    case (cmd)
      CMD_LOAD: begin
        if (stored_count < N_POINTS) begin
          n_loads++;
        end else begin
          n_full_loads++;
        end
      end
      CMD_CLEAR: begin
        n_clears++;
      end
      CMD_CLASSIFY: begin
        n_queries++;
      end
      default: n_unused++;
    endcase
    if (apply_beat(cmd, x, y, lab, v)) expected_verdicts.push_back(typed ? want : v);
    @(negedge clk);
  endtask

  // Drop valid, wait for every result, then let any load or clear finish
  task automatic settle_block();
    in_if.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write k over the register port and read it back
  task automatic set_neighbours(input logic [KCFG_W-1:0] k);
    logic [CFG_DATA_W-1:0] got;
    settle_block();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_NEIGHBOUR_COUNT, 2'b00};
    pwdata  <= CFG_DATA_W'(k);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    k_setting = k;
    k_seen[k] = 1'b1;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== CFG_DATA_W'(k)) begin
      errors++;
      $display("%0t ns: neighbour_count readback mismatch, expected %0d, actual %0d",
               $time, k, got);
    end
  endtask

  // Stimulus
  initial begin
    int episode;
    int n_load;
    int n_query;
    int sel;
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_if.valid   = 1'b0;
    in_if.command = CMD_LOAD;
    in_if.coord_x = '0;
    in_if.coord_y = '0;
    in_if.label   = 1'b0;
    out_if.ready  = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset value of k
    foreach (directed_plan[i]) begin
      push_beat(directed_plan[i].command, directed_plan[i].x, directed_plan[i].y,
                directed_plan[i].label, directed_plan[i].typed, directed_plan[i].want);
    end

    // Random episodes: optional k change and clear, a run of loads, some queries
    episode = 0;
    while (beats_counted < TARGET_BEATS) begin
      if (beats_counted < TARGET_BEATS / 3) begin
        send_idle = 9;
        recv_idle = 85;
      end else if (beats_counted < 2 * TARGET_BEATS / 3) begin
        send_idle = 85;
        recv_idle = 9;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (episode)
        0: set_neighbours(4'd0);
        1: set_neighbours(4'd15);
        2: set_neighbours(4'd1);
        default: if ($urandom_range(99) < 35) set_neighbours(KCFG_W'($urandom_range(15)));
      endcase
      if ($urandom_range(99) < 45) push_beat(CMD_CLEAR, pick_coord(), pick_coord(),
                                             1'($urandom), 1'b0, '0);
      sel = $urandom_range(99);
      if (sel < 30) n_load = $urandom_range(4);
      else if (sel < 70) n_load = $urandom_range(20, 5);
      else n_load = $urandom_range(70, 21);
      for (int i = 0; i < n_load; i++) begin
        // inject an occasional unused command or a stray clear
        sel = $urandom_range(99);
        if (sel < 3) push_beat(CMD_UNUSED, pick_coord(), pick_coord(), 1'($urandom), 1'b0, '0);
        else if (sel < 5) push_beat(CMD_CLEAR, pick_coord(), pick_coord(), 1'($urandom),
                                    1'b0, '0);
        push_beat(CMD_LOAD, pick_coord(), pick_coord(), 1'($urandom), 1'b0, '0);
      end
      n_query = $urandom_range(6, 1);
      for (int i = 0; i < n_query; i++) begin
        push_beat(CMD_CLASSIFY, pick_coord(), pick_coord(), 1'($urandom), 1'b0, '0);
      end
      episode++;
    end

    settle_block();
    if (expected_verdicts.size() != 0) begin
      errors++;
      $display("%0t ns: %0d results never arrived", $time, expected_verdicts.size());
    end
    $display("summary: %0d queries over %0d result beats, %0d loads, %0d loads into a full store",
             n_queries, results_seen, n_loads, n_full_loads);
    $display("summary: %0d clears, %0d unused-command beats, %0d k values, %0d mismatches",
             n_clears, n_unused, $countones(k_seen), errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("timeout waiting on the block");
    $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
design/knnbc_pkg.sv
design/knnbc_in_if.sv
design/knnbc_out_if.sv
design/knnbc_point_mem.sv
design/knnbc_dist.sv
design/knnbc_best_list.sv
design/knn_binary_classifier_core.sv
design/knnbc_checker.sv
tb/sv/tb_knn_binary_classifier_core.sv
